@@ design/wtr_pkg.sv @@
// Shared constants, types and the gamma threshold table for the wavelength-to-RGB block.
`timescale 1ns / 1ps
`default_nettype none
package wtr_pkg;

	// Number formats
	localparam int WAVE_FRAC_BITS = 6;
	localparam int GAMMA_BITS     = 10;
	localparam int WAVE_W         = 16;
	// Wide enough for 780 nm at any fraction setting
	localparam int NM_W           = (10 + WAVE_FRAC_BITS > WAVE_W) ? 10 + WAVE_FRAC_BITS : WAVE_W;
	localparam int Q12_FRAC       = 12;
	localparam int Q12_W          = 13;
	localparam int LVL_W          = 8;
	localparam int NUM_CH         = 3;
	localparam int SRCH_STAGES    = LVL_W;

	// Band edges in wavelength units
	localparam logic [NM_W-1:0] NM_380 = NM_W'(380 << WAVE_FRAC_BITS);
	localparam logic [NM_W-1:0] NM_420 = NM_W'(420 << WAVE_FRAC_BITS);
	localparam logic [NM_W-1:0] NM_440 = NM_W'(440 << WAVE_FRAC_BITS);
	localparam logic [NM_W-1:0] NM_490 = NM_W'(490 << WAVE_FRAC_BITS);
	localparam logic [NM_W-1:0] NM_510 = NM_W'(510 << WAVE_FRAC_BITS);
	localparam logic [NM_W-1:0] NM_580 = NM_W'(580 << WAVE_FRAC_BITS);
	localparam logic [NM_W-1:0] NM_645 = NM_W'(645 << WAVE_FRAC_BITS);
	localparam logic [NM_W-1:0] NM_700 = NM_W'(700 << WAVE_FRAC_BITS);
	localparam logic [NM_W-1:0] NM_780 = NM_W'(780 << WAVE_FRAC_BITS);

	localparam logic [Q12_W-1:0] ONE_Q12 = Q12_W'(4096);
	localparam logic [Q12_W-1:0] S_MIN   = Q12_W'(1229);
	localparam logic [11:0]      S_SPAN  = 12'd2867;

	// Ramp numerator dist << (12 - frac) is at most 70 * 4096,
	// fade numerator (dist * 2867) >> frac below 80 * 2867
	localparam int RAMP_NUM_W = 19;
	localparam int FADE_NUM_W = 18;
	localparam int WIDE_W     = NM_W + Q12_FRAC;

	// Exact division by small constants: q = (x * ceil(2^30 / n)) >> 30 while x * n < 2^30
	localparam int RECIP_SHIFT = 30;
	localparam int RECIP_W     = 26;
	localparam logic [RECIP_W-1:0] RECIP_20 = RECIP_W'(((1 << RECIP_SHIFT) + 19) / 20);
	localparam logic [RECIP_W-1:0] RECIP_40 = RECIP_W'(((1 << RECIP_SHIFT) + 39) / 40);
	localparam logic [RECIP_W-1:0] RECIP_50 = RECIP_W'(((1 << RECIP_SHIFT) + 49) / 50);
	localparam logic [RECIP_W-1:0] RECIP_60 = RECIP_W'(((1 << RECIP_SHIFT) + 59) / 60);
	localparam logic [RECIP_W-1:0] RECIP_65 = RECIP_W'(((1 << RECIP_SHIFT) + 64) / 65);
	localparam logic [RECIP_W-1:0] RECIP_70 = RECIP_W'(((1 << RECIP_SHIFT) + 69) / 70);
	localparam logic [RECIP_W-1:0] RECIP_80 = RECIP_W'(((1 << RECIP_SHIFT) + 79) / 80);

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {
		BAND_VIOLET,	// 380..440: red falls, blue full
		BAND_BLUE,	// 440..490: green rises, blue full
		BAND_CYAN,	// 490..510: green full, blue falls
		BAND_GREEN,	// 510..580: red rises, green full
		BAND_YELLOW,	// 580..645: red full, green falls
		BAND_RED	// 645..780: red full
	} band_t;

	typedef enum logic [1:0] {
		FADE_NONE,
		FADE_LOW,	// 380..420
		FADE_HIGH	// 700..780
	} fade_t;

	typedef struct packed {
		logic                  black;
		band_t                 band;
		logic [RAMP_NUM_W-1:0] ramp_num;
		fade_t                 fade;
		logic [FADE_NUM_W-1:0] fade_num;
	} item_t;

	typedef logic [NUM_CH-1:0][Q12_W-1:0]      q12_vec_t;
	typedef logic [NUM_CH-1:0][GAMMA_BITS-1:0] gidx_vec_t;
	typedef logic [NUM_CH-1:0][LVL_W-1:0]      lvl_vec_t;

	localparam int GAMMA_MAX = (1 << GAMMA_BITS) - 1;

	// Entry y: smallest index i with 255^5 * i^4 >= y^5 * M^4.
	// gamma(i) >= y exactly when entry y <= i.
	function automatic logic [256*GAMMA_BITS-1:0] gamma_thr_build();
		logic [256*GAMMA_BITS-1:0] tab;
		logic [127:0] m, m4, k5, yy, lhs, ii, rhs;
		int lo, hi, mid;
		tab = '0;
		m   = 128'(GAMMA_MAX);
		m4  = m * m * m * m;
		k5  = 128'(255) * 128'(255) * 128'(255) * 128'(255) * 128'(255);
		for (int y = 0; y < 256; y++) begin
			yy  = 128'(y);
			lhs = yy * yy * yy * yy * yy * m4;
			lo  = 0;
			hi  = GAMMA_MAX;
			for (int n = 0; n <= GAMMA_BITS; n++) begin
				if (lo < hi) begin
					mid = (lo + hi) >> 1;
					ii  = 128'(mid);
					rhs = k5 * ii * ii * ii * ii;
					if (rhs >= lhs) begin
						hi = mid;
					end else begin
						lo = mid + 1;
					end
				end
			end
			tab[y*GAMMA_BITS +: GAMMA_BITS] = GAMMA_BITS'(lo);
		end
		return tab;
	endfunction

	localparam logic [256*GAMMA_BITS-1:0] GAMMA_THR = gamma_thr_build();

	function automatic logic [GAMMA_BITS-1:0] gamma_thr(input logic [LVL_W-1:0] t);
		return GAMMA_THR[GAMMA_BITS*t +: GAMMA_BITS];
	endfunction

endpackage
`default_nettype wire

@@ design/wavelength_to_rgb.sv @@
// Top level of the wavelength-to-RGB colour block.
`timescale 1ns / 1ps
`default_nettype none
// Converts one wavelength (nm, 6 fraction bits) into an 8-bit red, green and blue
// triple after the visible-spectrum approximation with a 0.8 gamma. A transfer in
// takes place at a rising edge with start high and busy low; one new wavelength can
// be taken on every clock. Each colour comes out for exactly one cycle with done
// high, in input order, after the queue register and the stages named below; the
// receiver has no way to hold it off, so it must take the colour in that cycle.
// The colour pipeline never stalls, so the queue behind the front end drains every
// cycle and busy stays low under any start pattern. The path runs through the
// queue register, three arithmetic stages (constant divisions, channel times fade,
// gamma index) and an eight-stage search of the gamma threshold table, one bit of
// the 8-bit level per stage. Wavelengths outside 380..780 nm give black.
module wavelength_to_rgb (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [wtr_pkg::WAVE_W-1:0]    wavelength,
	output logic                               done,
	output logic [wtr_pkg::LVL_W-1:0]          red,
	output logic [wtr_pkg::LVL_W-1:0]          green,
	output logic [wtr_pkg::LVL_W-1:0]          blue
);

	// front end -> queue
	logic           push;
	wtr_pkg::item_t fe_item;
	logic           q_full;

	// queue -> colour pipeline
	logic           q_vld;
	wtr_pkg::item_t q_item;

	// classification: band, fade region, numerators for the constant divides
	wtr_front u_front (
		.start      (start),
		.full       (q_full),
		.wavelength (wavelength),
		.push       (push),
		.item       (fe_item)
	);

	// two-entry decoupling queue; busy is its full flag
	wtr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item_in  (fe_item),
		.full     (q_full),
		.item_vld (q_vld),
		.item_out (q_item)
	);

	// arithmetic and gamma lookup; result registers drive the outputs directly
	wtr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.item_vld (q_vld),
		.item     (q_item),
		.done     (done),
		.red      (red),
		.green    (green),
		.blue     (blue)
	);

	assign busy = q_full;

endmodule
`default_nettype wire

@@ design/wtr_front.sv @@
// Front end: takes a wavelength, picks its band and edge fade, forms the division numerators.
`timescale 1ns / 1ps
`default_nettype none
module wtr_front (
	input  wire logic                          start,
	input  wire logic                          full,
	input  wire logic [wtr_pkg::WAVE_W-1:0]    wavelength,
	output logic                               push,
	output wtr_pkg::item_t                     item
);

	logic [wtr_pkg::NM_W-1:0]   w;
	logic [wtr_pkg::NM_W-1:0]   rdist;
	logic [wtr_pkg::NM_W-1:0]   fdist;
	logic [wtr_pkg::WIDE_W-1:0] ramp_wide;
	logic [wtr_pkg::WIDE_W-1:0] fade_wide;

	assign push = start && !full;
	assign w    = wtr_pkg::NM_W'(wavelength);

	always_comb begin
		item.black = (w < wtr_pkg::NM_380) || (w > wtr_pkg::NM_780);

		// first matching band wins, shared edges go to the lower band
		if (w <= wtr_pkg::NM_440) begin
			item.band = wtr_pkg::BAND_VIOLET;
			rdist     = wtr_pkg::NM_440 - w;
		end else if (w <= wtr_pkg::NM_490) begin
			item.band = wtr_pkg::BAND_BLUE;
			rdist     = w - wtr_pkg::NM_440;
		end else if (w <= wtr_pkg::NM_510) begin
			item.band = wtr_pkg::BAND_CYAN;
			rdist     = wtr_pkg::NM_510 - w;
		end else if (w <= wtr_pkg::NM_580) begin
			item.band = wtr_pkg::BAND_GREEN;
			rdist     = w - wtr_pkg::NM_510;
		end else if (w <= wtr_pkg::NM_645) begin
			item.band = wtr_pkg::BAND_YELLOW;
			rdist     = wtr_pkg::NM_645 - w;
		end else begin
			item.band = wtr_pkg::BAND_RED;
			rdist     = '0;
		end

		if (w > wtr_pkg::NM_700) begin
			item.fade = wtr_pkg::FADE_HIGH;
			fdist     = wtr_pkg::NM_780 - w;
		end else if (w < wtr_pkg::NM_420) begin
			item.fade = wtr_pkg::FADE_LOW;
			fdist     = w - wtr_pkg::NM_380;
		end else begin
			item.fade = wtr_pkg::FADE_NONE;
			fdist     = '0;
		end

		// ramp = (dist << (12 - frac)) / span_nm, fade = ((dist * 2867) >> frac) / span_nm
		ramp_wide     = wtr_pkg::WIDE_W'(rdist) << (wtr_pkg::Q12_FRAC - wtr_pkg::WAVE_FRAC_BITS);
		fade_wide     = (wtr_pkg::WIDE_W'(fdist) * wtr_pkg::WIDE_W'(wtr_pkg::S_SPAN))
				>> wtr_pkg::WAVE_FRAC_BITS;
		item.ramp_num = ramp_wide[wtr_pkg::RAMP_NUM_W-1:0];
		item.fade_num = fade_wide[wtr_pkg::FADE_NUM_W-1:0];
	end

endmodule
`default_nettype wire

@@ design/wtr_queue.sv @@
// Short queue between the front end and the colour pipeline.
`timescale 1ns / 1ps
`default_nettype none
module wtr_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire wtr_pkg::item_t item_in,
	output logic                full,
	output logic                item_vld,
	output wtr_pkg::item_t      item_out
);

	wtr_pkg::item_t                mem_q [wtr_pkg::QUEUE_DEPTH];
	logic [wtr_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [wtr_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [wtr_pkg::QCNT_W-1:0]    cnt_q;
	logic                          pop;

	// the back end never stalls, so the head leaves as soon as it is there
	assign pop      = (cnt_q != '0);
	assign item_vld = pop;
	assign item_out = mem_q[rd_ptr_q];
	assign full     = (cnt_q == wtr_pkg::QCNT_W'(wtr_pkg::QUEUE_DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + wtr_pkg::QCNT_W'(push) - wtr_pkg::QCNT_W'(pop);
		end
	end

endmodule
`default_nettype wire

@@ design/wtr_gamma.sv @@
// Gamma lookup: bit-per-stage search of the threshold table, three channels side by side.
`timescale 1ns / 1ps
`default_nettype none
module wtr_gamma (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_vld,
	input  wire wtr_pkg::gidx_vec_t  idx,
	output logic                     out_vld,
	output wtr_pkg::lvl_vec_t        lvl
);

	localparam int NS = wtr_pkg::SRCH_STAGES;

	wtr_pkg::lvl_vec_t  y_s   [NS];
	wtr_pkg::gidx_vec_t idx_s [NS];
	logic [NS-1:0]      vld_s;

	wtr_pkg::lvl_vec_t  y_in   [NS];
	wtr_pkg::gidx_vec_t idx_in [NS];
	wtr_pkg::lvl_vec_t  y_nxt  [NS];

	always_comb begin
		y_in[0]   = '0;
		idx_in[0] = idx;
		for (int k = 1; k < NS; k++) begin
			y_in[k]   = y_s[k-1];
			idx_in[k] = idx_s[k-1];
		end
	end

	// stage k settles bit (7 - k) of each level
	always_comb begin
		for (int k = 0; k < NS; k++) begin
			for (int ch = 0; ch < wtr_pkg::NUM_CH; ch++) begin
				if (wtr_pkg::gamma_thr(y_in[k][ch] | wtr_pkg::LVL_W'(1 << (NS - 1 - k)))
						<= idx_in[k][ch]) begin
					y_nxt[k][ch] = y_in[k][ch] | wtr_pkg::LVL_W'(1 << (NS - 1 - k));
				end else begin
					y_nxt[k][ch] = y_in[k][ch];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < NS; k++) begin
			y_s[k]   <= y_nxt[k];
			idx_s[k] <= idx_in[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[NS-2:0], in_vld};
		end
	end

	assign out_vld = vld_s[NS-1];
	assign lvl     = y_s[NS-1];

endmodule
`default_nettype wire

@@ design/wtr_back.sv @@
// Back end: constant divisions, channel ramps, edge fade, gamma index and lookup.
`timescale 1ns / 1ps
`default_nettype none
module wtr_back (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         item_vld,
	input  wire wtr_pkg::item_t               item,
	output logic                              done,
	output logic [wtr_pkg::LVL_W-1:0]         red,
	output logic [wtr_pkg::LVL_W-1:0]         green,
	output logic [wtr_pkg::LVL_W-1:0]         blue
);

	localparam int RPROD_W = wtr_pkg::RAMP_NUM_W + wtr_pkg::RECIP_W;
	localparam int FPROD_W = wtr_pkg::FADE_NUM_W + wtr_pkg::RECIP_W;
	localparam int PM_W    = wtr_pkg::Q12_W + wtr_pkg::GAMMA_BITS;

	// stage 1: reciprocal multiplies
	logic [wtr_pkg::RECIP_W-1:0] ramp_recip;
	logic [wtr_pkg::RECIP_W-1:0] fade_recip;
	logic [RPROD_W-1:0]          ramp_prod;
	logic [FPROD_W-1:0]          fade_prod;

	logic                        vld_s1;
	logic                        black_s1;
	wtr_pkg::band_t              band_s1;
	wtr_pkg::fade_t              fade_s1;
	logic [wtr_pkg::Q12_W-1:0]   ramp_s1;
	logic [11:0]                 fadeq_s1;

	// stage 2: channel * fade
	wtr_pkg::q12_vec_t           chan;
	logic [wtr_pkg::Q12_W-1:0]   scale;
	logic [2*wtr_pkg::Q12_W-1:0] prod [wtr_pkg::NUM_CH];
	logic                        vld_s2;
	wtr_pkg::q12_vec_t           p_s2;

	// stage 3: gamma index
	logic [PM_W-1:0]             pm [wtr_pkg::NUM_CH];
	logic                        vld_s3;
	wtr_pkg::gidx_vec_t          idx_s3;

	logic                        lut_vld;
	wtr_pkg::lvl_vec_t           lvl;

	always_comb begin
		case (item.band)
			wtr_pkg::BAND_VIOLET: ramp_recip = wtr_pkg::RECIP_60;
			wtr_pkg::BAND_BLUE:   ramp_recip = wtr_pkg::RECIP_50;
			wtr_pkg::BAND_CYAN:   ramp_recip = wtr_pkg::RECIP_20;
			wtr_pkg::BAND_GREEN:  ramp_recip = wtr_pkg::RECIP_70;
			wtr_pkg::BAND_YELLOW: ramp_recip = wtr_pkg::RECIP_65;
			default:              ramp_recip = '0;
		endcase
		fade_recip = (item.fade == wtr_pkg::FADE_LOW) ? wtr_pkg::RECIP_40 : wtr_pkg::RECIP_80;
		ramp_prod  = RPROD_W'(item.ramp_num) * RPROD_W'(ramp_recip);
		fade_prod  = FPROD_W'(item.fade_num) * FPROD_W'(fade_recip);
	end

	always_ff @(posedge clk) begin
		black_s1 <= item.black;
		band_s1  <= item.band;
		fade_s1  <= item.fade;
		ramp_s1  <= ramp_prod[wtr_pkg::RECIP_SHIFT +: wtr_pkg::Q12_W];
		fadeq_s1 <= fade_prod[wtr_pkg::RECIP_SHIFT +: 12];
	end

	always_comb begin
		chan = '0;
		case (band_s1)
			wtr_pkg::BAND_VIOLET: begin
				chan[0] = ramp_s1;
				chan[2] = wtr_pkg::ONE_Q12;
			end
			wtr_pkg::BAND_BLUE: begin
				chan[1] = ramp_s1;
				chan[2] = wtr_pkg::ONE_Q12;
			end
			wtr_pkg::BAND_CYAN: begin
				chan[1] = wtr_pkg::ONE_Q12;
				chan[2] = ramp_s1;
			end
			wtr_pkg::BAND_GREEN: begin
				chan[0] = ramp_s1;
				chan[1] = wtr_pkg::ONE_Q12;
			end
			wtr_pkg::BAND_YELLOW: begin
				chan[0] = wtr_pkg::ONE_Q12;
				chan[1] = ramp_s1;
			end
			wtr_pkg::BAND_RED: begin
				chan[0] = wtr_pkg::ONE_Q12;
			end
			default: begin
				chan = '0;
			end
		endcase
		// out of range: zero channels, and gamma of zero is zero
		if (black_s1) begin
			chan = '0;
		end
		if (fade_s1 == wtr_pkg::FADE_NONE) begin
			scale = wtr_pkg::ONE_Q12;
		end else begin
			scale = wtr_pkg::S_MIN + wtr_pkg::Q12_W'(fadeq_s1);
		end
		for (int ch = 0; ch < wtr_pkg::NUM_CH; ch++) begin
			prod[ch] = (2*wtr_pkg::Q12_W)'(chan[ch]) * (2*wtr_pkg::Q12_W)'(scale);
		end
	end

	always_ff @(posedge clk) begin
		for (int ch = 0; ch < wtr_pkg::NUM_CH; ch++) begin
			p_s2[ch] <= prod[ch][wtr_pkg::Q12_FRAC +: wtr_pkg::Q12_W];
		end
	end

	// index = (p * (2^G - 1)) >> 12, at most 2^G - 1 since p <= 4096
	always_comb begin
		for (int ch = 0; ch < wtr_pkg::NUM_CH; ch++) begin
			pm[ch] = {p_s2[ch], {wtr_pkg::GAMMA_BITS{1'b0}}} - PM_W'(p_s2[ch]);
		end
	end

	always_ff @(posedge clk) begin
		for (int ch = 0; ch < wtr_pkg::NUM_CH; ch++) begin
			idx_s3[ch] <= pm[ch][wtr_pkg::Q12_FRAC +: wtr_pkg::GAMMA_BITS];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= item_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	wtr_gamma u_gamma (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (vld_s3),
		.idx     (idx_s3),
		.out_vld (lut_vld),
		.lvl     (lvl)
	);

	assign done  = lut_vld;
	assign red   = lvl[0];
	assign green = lvl[1];
	assign blue  = lvl[2];

endmodule
`default_nettype wire

@@ tb/sv/wtr_colour_checker.sv @@
// Checker for the wavelength-to-RGB block: predicts each colour and compares it.
`timescale 1ns / 1ps
`default_nettype none
module wtr_colour_checker (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic                       busy,
	input  wire logic [wtr_pkg::WAVE_W-1:0] wavelength,
	input  wire logic                       done,
	input  wire logic [wtr_pkg::LVL_W-1:0]  red,
	input  wire logic [wtr_pkg::LVL_W-1:0]  green,
	input  wire logic [wtr_pkg::LVL_W-1:0]  blue,
	output int                              mismatches,
	output int                              in_flight
);

	localparam int FRAC = wtr_pkg::WAVE_FRAC_BITS;
	localparam int LUT_SIZE = 1 << wtr_pkg::GAMMA_BITS;
	localparam longint unsigned LUT_TOP = LUT_SIZE - 1;
	localparam longint unsigned FULL = 4096;
	localparam longint unsigned FADE_FLOOR = 1229;
	localparam longint unsigned FADE_RISE = 2867;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} colour_t;

	logic [7:0] gamma_lut [LUT_SIZE];
	colour_t    colour_q [$];

	// Gamma 0.8 curve: level is the largest y with y^5 * top^4 <= 255^5 * i^4.
	// Levels rise with the index, so one running level serves the whole table.
	initial begin : build_lut
		logic [127:0] top4, full5, rhs, nxt;
		int lvl;
		top4  = 128'(LUT_TOP) * 128'(LUT_TOP) * 128'(LUT_TOP) * 128'(LUT_TOP);
		full5 = 128'(255) * 128'(255) * 128'(255) * 128'(255) * 128'(255);
		lvl   = 0;
		for (int i = 0; i < LUT_SIZE; i++) begin
			rhs = full5 * 128'(i) * 128'(i) * 128'(i) * 128'(i);
			while (lvl < 255) begin
				nxt = 128'(lvl + 1);
				if (nxt * nxt * nxt * nxt * nxt * top4 <= rhs) begin
					lvl++;
				end else begin
					break;
				end
			end
			gamma_lut[i] = 8'(lvl);
		end
	end

	function automatic longint unsigned nm_units(input int unsigned n);
		return 64'(n) << FRAC;
	endfunction

	function automatic longint unsigned q12_ramp(input longint unsigned offset,
			input int unsigned span_nm);
		return (offset * FULL) / nm_units(span_nm);
	endfunction

	function automatic logic [7:0] graded(input longint unsigned chan,
			input longint unsigned fade);
		longint unsigned prod, idx;
		prod = (chan * fade) >> 12;
		idx  = (prod * LUT_TOP) >> 12;
		if (idx > LUT_TOP) idx = LUT_TOP;
		return gamma_lut[idx];
	endfunction

	function automatic colour_t colour_of(input logic [wtr_pkg::WAVE_W-1:0] w);
		longint unsigned lam, rr, gg, bb, fade;
		colour_t c;
		lam = 64'(w);
		rr = 0;
		gg = 0;
		bb = 0;
		fade = FULL;
		if (lam < nm_units(380) || lam > nm_units(780)) return '0;
		// shared band edges belong to the lower band
		if (lam <= nm_units(440)) begin
			rr = q12_ramp(nm_units(440) - lam, 60);
			bb = FULL;
		end else if (lam <= nm_units(490)) begin
			gg = q12_ramp(lam - nm_units(440), 50);
			bb = FULL;
		end else if (lam <= nm_units(510)) begin
			gg = FULL;
			bb = q12_ramp(nm_units(510) - lam, 20);
		end else if (lam <= nm_units(580)) begin
			rr = q12_ramp(lam - nm_units(510), 70);
			gg = FULL;
		end else if (lam <= nm_units(645)) begin
			rr = FULL;
			gg = q12_ramp(nm_units(645) - lam, 65);
		end else begin
			rr = FULL;
		end
		if (lam > nm_units(700))
			fade = FADE_FLOOR + ((nm_units(780) - lam) * FADE_RISE) / nm_units(80);
		else if (lam < nm_units(420))
			fade = FADE_FLOOR + ((lam - nm_units(380)) * FADE_RISE) / nm_units(40);
		c.r = graded(rr, fade);
		c.g = graded(gg, fade);
		c.b = graded(bb, fade);
		return c;
	endfunction

	always @(posedge clk) begin : watch
		colour_t want;
		int bad;
		bad = 0;
		if (arst_n) begin
			if (start && !busy) colour_q.push_back(colour_of(wavelength));
			if (done) begin
				if (colour_q.size() == 0) begin
					$error("colour out with none expected: %0d %0d %0d", red, green, blue);
					bad++;
				end else begin
					want = colour_q.pop_front();
					if (red !== want.r) begin
						$error("red: expected %0d, got %0d", want.r, red);
						bad++;
					end
					if (green !== want.g) begin
						$error("green: expected %0d, got %0d", want.g, green);
						bad++;
					end
					if (blue !== want.b) begin
						$error("blue: expected %0d, got %0d", want.b, blue);
						bad++;
					end
				end
			end
			mismatches <= mismatches + bad;
			in_flight  <= colour_q.size();
		end
	end

endmodule
`default_nettype wire

@@ tb/sv/tb_wavelength_to_rgb.sv @@
// Testbench top for the wavelength-to-RGB block: stimulus, timeout and verdict.
`timescale 1ns / 1ps
`default_nettype none
module tb_wavelength_to_rgb;

	localparam int FRAC = wtr_pkg::WAVE_FRAC_BITS;
	localparam int RANDOM_ITEMS = 950;
	// Roughly 975 items with random gaps between bursts;
	// the limit leaves a wide margin over the length of that run.
	localparam int CYCLE_LIMIT = 200000;

	logic                       clk;
	logic                       arst_n;
	logic                       start;
	logic                       busy;
	logic [wtr_pkg::WAVE_W-1:0] wavelength;
	logic                       done;
	logic [wtr_pkg::LVL_W-1:0]  red;
	logic [wtr_pkg::LVL_W-1:0]  green;
	logic [wtr_pkg::LVL_W-1:0]  blue;
	int                         mismatches;
	int                         in_flight;
	int                         cycles;

	wavelength_to_rgb dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.wavelength (wavelength),
		.done       (done),
		.red        (red),
		.green      (green),
		.blue       (blue)
	);

	wtr_colour_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.wavelength (wavelength),
		.done       (done),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.mismatches (mismatches),
		.in_flight  (in_flight)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog: a hang anywhere ends the run as a failure.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[wavelength_to_rgb] ERROR");
			$finish;
		end
	end

	function automatic logic [15:0] at_nm(input int unsigned n);
		return 16'(n << FRAC);
	endfunction

	// Band and fade edges, picked by index for the edge-hugging random mode.
	function automatic int unsigned edge_nm(input int unsigned k);
		case (k)
			0: return 380;
			1: return 420;
			2: return 440;
			3: return 490;
			4: return 510;
			5: return 580;
			6: return 645;
			7: return 700;
			default: return 780;
		endcase
	endfunction

	// Mostly in-band wavelengths with random fractions, a good share right on
	// or beside an edge, and the rest anywhere in the 16-bit field.
	function automatic logic [15:0] pick_wavelength();
		int unsigned mode;
		int offs;
		mode = $urandom_range(0, 99);
		if (mode < 55) begin
			return 16'($urandom_range(380 << FRAC, 780 << FRAC));
		end else if (mode < 80) begin
			offs = int'($urandom_range(0, 8)) - 4;
			return 16'(int'(edge_nm($urandom_range(0, 8)) << FRAC) + offs);
		end else if (mode < 95) begin
			return 16'($urandom);
		end else begin
			return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'($urandom_range(0, 3));
		end
	endfunction

	// One input transfer. busy only moves at rising edges, so its value at the
	// falling edge is the one the block sees at the next rising edge.
	task automatic send_wavelength(input logic [15:0] w);
		logic taken;
		start      <= 1'b1;
		wavelength <= w;
		do begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end while (!taken);
	endtask

	task automatic pause(input int unsigned n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	initial begin : stimulus
		int unsigned burst, sent;
		logic [15:0] directed [$];

		arst_n     = 1'b0;
		start      = 1'b0;
		wavelength = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: field extremes, either side of black, every band and
		// its shared edge, both fade edges.
		directed = '{16'h0000, 16'hFFFF, 16'h0001,
			at_nm(380) - 16'd1, at_nm(380), at_nm(380) + 16'd1,
			at_nm(420) - 16'd1, at_nm(420),
			at_nm(440), at_nm(440) + 16'd1,
			at_nm(490), at_nm(490) + 16'd1,
			at_nm(510), at_nm(510) + 16'd1,
			at_nm(580), at_nm(580) + 16'd1,
			at_nm(645), at_nm(645) + 16'd1,
			at_nm(700), at_nm(700) + 16'd1,
			at_nm(780) - 16'd1, at_nm(780), at_nm(780) + 16'd1,
			at_nm(555) + 16'd37};
		foreach (directed[i]) send_wavelength(directed[i]);
		pause(3);

		// Random part: bursts of back-to-back transfers with random gaps,
		// now and then a long unbroken stretch.
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			burst = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120)
			                                     : $urandom_range(1, 20);
			repeat (burst) begin
				send_wavelength(pick_wavelength());
				sent++;
			end
			pause($urandom_range(1, 8));
		end

		// Drain: every colour must have come out, then more than a latency's
		// worth of quiet to catch stray strobes.
		while (in_flight != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0) begin
			$display("[wavelength_to_rgb] OK");
		end else begin
			$display("[wavelength_to_rgb] ERROR");
		end
		$finish;
	end

endmodule
`default_nettype wire
